[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro builds one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lpf_pkg.sv]
// ----------------------------------------------------------------------------
// lpf_pkg
// Types and constants shared by the longest previous factor stack block.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int POS_W = 20;
  localparam int LCP_W = 20;

  // Action codes of an input beat.
  localparam logic ACT_ENTRY = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Number of slots in the queue between front and back.
  localparam int Q_DEPTH = 2;

  // One input beat.
  typedef struct packed {
    logic             action;
    logic [POS_W-1:0] suffix_position;
    logic [LCP_W-1:0] common_prefix;
  } lpf_in_t;

  // One result beat.
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [LCP_W-1:0] factor_length;
    logic [POS_W-1:0] previous_position;
    logic             has_previous;
    logic             last_of_run;
    logic             overflow;
  } lpf_out_t;

  // A classified command from the front to the back.
  typedef struct packed {
    logic             flush;
    logic [POS_W-1:0] pos;
    logic [LCP_W-1:0] lcp;
  } lpf_cmd_t;

  // One stack entry.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LCP_W-1:0] lcp;
  } lpf_entry_t;

  localparam int ENTRY_W = $bits(lpf_entry_t);

  // Back end: whether the running lcp register holds the current item's value.
  typedef enum logic {
    ST_FRESH,
    ST_RUN
  } lpf_state_t;

  // Stack status reported by the back end.
  typedef struct packed {
    logic empty;
    logic full;
    logic overflow;
  } lpf_status_t;

endpackage

[rtl/lpf_ram.sv]
// ----------------------------------------------------------------------------
// lpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lpf_front.sv]
// ----------------------------------------------------------------------------
// lpf_front
// Accepts input beats and classifies them: flush or entry, and the lcp that
// the entry really carries (zero for a flush and for the first entry of a text).
// ----------------------------------------------------------------------------
module lpf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  lpf_pkg::lpf_in_t  in_data,
  output logic              in_ready,
  input  logic              q_full,
  output logic              q_push,
  output lpf_pkg::lpf_cmd_t q_cmd
);
  import lpf_pkg::*;

  logic started_r;
  logic started_nxt;
  logic is_flush;

  assign is_flush = (in_data.action == ACT_FLUSH);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Build the command; the lcp counts only inside a text after its first entry.
  always_comb begin
    q_cmd.flush = is_flush;
    q_cmd.pos   = in_data.suffix_position;
    q_cmd.lcp   = (is_flush || !started_r) ? '0 : in_data.common_prefix;
  end

  // A text starts with its first entry and ends with a flush.
  always_comb begin
    started_nxt = started_r;
    if (q_push) begin
      started_nxt = !is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

endmodule

[rtl/lpf_queue.sv]
// ----------------------------------------------------------------------------
// lpf_queue
// Short command queue that decouples the front from the stack engine.
// ----------------------------------------------------------------------------
module lpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpf_pkg::lpf_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output lpf_pkg::lpf_cmd_t head_cmd
);
  import lpf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  lpf_cmd_t         slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/lpf_back.sv]
// ----------------------------------------------------------------------------
// lpf_back
// Stack engine: pops one entry per cycle into the result register while the
// result is not stalled, then pushes the item or empties the stack on a flush.
// ----------------------------------------------------------------------------
module lpf_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  lpf_pkg::lpf_cmd_t    head_cmd,
  output logic                 head_pop,
  output logic                 out_valid,
  output lpf_pkg::lpf_out_t    out_data,
  input  logic                 out_ready,
  output lpf_pkg::lpf_status_t status
);
  import lpf_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  lpf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  lpf_entry_t       top_r, top_nxt;
  logic [LCP_W-1:0] cur_r, cur_nxt;
  logic             overflow_r, overflow_nxt;
  lpf_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  lpf_entry_t       below;
  logic [ENTRY_W-1:0] rd_data;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] count_pop;
  logic [LCP_W-1:0] cur_eff, cur_min, cur_after, len;
  logic             pop_want, do_pop, out_free, deeper, more, finish;
  logic             top_gt, has, push;
  lpf_entry_t       push_entry;

  // The RAM presents the entry under the top of the stack whenever there is one.
  lpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count_pop[ADDR_W-1:0]),
    .wr_data (push_entry),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign below  = lpf_entry_t'(rd_data);
  assign rd_idx = count_nxt - CNT_W'(2);

  // Pop decision and result fields.
  always_comb begin
    cur_eff  = (state_r == ST_FRESH) ? head_cmd.lcp : cur_r;
    pop_want = head_valid && (count_r != '0) &&
               (head_cmd.flush || (head_cmd.pos < top_r.pos));
    out_free = !out_valid_r || out_ready;
    do_pop   = pop_want && out_free;
    deeper   = (count_r >= CNT_W'(2));
    more     = deeper && (head_cmd.flush || (head_cmd.pos < below.pos));
    finish   = head_valid && (!pop_want || (do_pop && !more));

    top_gt   = (top_r.lcp > cur_eff);
    len      = top_gt ? top_r.lcp : cur_eff;
    cur_min  = top_gt ? cur_eff : top_r.lcp;
    has      = (len != '0) && (top_gt ? deeper : !head_cmd.flush);

    out_nxt.position          = top_r.pos;
    out_nxt.factor_length     = len;
    out_nxt.previous_position = has ? (top_gt ? below.pos : head_cmd.pos) : '0;
    out_nxt.has_previous      = has;
    out_nxt.last_of_run       = !more;
    out_nxt.overflow          = overflow_r;
  end

  // Stack bookkeeping: pop, then push or flush when the item finishes.
  always_comb begin
    count_pop     = do_pop ? count_r - CNT_W'(1) : count_r;
    cur_after     = do_pop ? cur_min : cur_eff;
    push          = finish && !head_cmd.flush && (count_pop < CNT_W'(STACK_DEPTH));
    push_entry.pos = head_cmd.pos;
    push_entry.lcp = cur_after;

    count_nxt    = count_pop;
    top_nxt      = do_pop ? below : top_r;
    overflow_nxt = overflow_r;
    if (finish && head_cmd.flush) begin
      count_nxt = '0;
    end else if (push) begin
      count_nxt = count_pop + CNT_W'(1);
      top_nxt   = push_entry;
    end else if (finish) begin
      overflow_nxt = 1'b1;
    end

    cur_nxt   = do_pop ? cur_min : cur_r;
    state_nxt = state_r;
    if (finish) begin
      state_nxt = ST_FRESH;
    end else if (do_pop) begin
      state_nxt = ST_RUN;
    end

    out_valid_nxt = out_valid_r;
    if (do_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FRESH;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    cur_r <= cur_nxt;
    if (do_pop) begin
      out_r <= out_nxt;
    end
  end

  assign head_pop        = finish;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.empty    = (count_r == '0);
  assign status.full     = (count_r == CNT_W'(STACK_DEPTH));
  assign status.overflow = overflow_r;

endmodule

[rtl/longest_previous_factor_stack.sv]
// ----------------------------------------------------------------------------
// longest_previous_factor_stack
// Streams suffix array entries with their lcp and reports the longest
// previous factor of each text position as its stack entry is popped.
// ----------------------------------------------------------------------------
//  Channel | Ports                        | Beat
//  --------+------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data  | one suffix array entry or a flush
//  result  | out_valid, out_ready, out_data | one popped position
//
// An item leaves the queue in the cycle of its last pop, or in the cycle it
// reaches the head if it pops none; every entry is pushed once and popped
// once. One pop per cycle, while the result is not stalled, is set by the
// single stack RAM read port and the one result register. Reset is synchronous
// and empties the stack with no clearing pass. A stalled result holds the stack
// engine while the two-slot queue keeps taking input beats until it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_previous_factor_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpf_pkg::lpf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpf_pkg::lpf_out_t out_data
);
  import lpf_pkg::*;

  logic        q_full;
  logic        q_push;
  lpf_cmd_t    q_cmd;
  logic        q_pop;
  logic        q_head_valid;
  lpf_cmd_t    q_head;
  lpf_status_t stat;

  // Front: classification of input beats.
  lpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Queue between front and back.
  lpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  // Back: the stack engine.
  lpf_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .head_pop   (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready),
    .status     (stat)
  );

  // A finished flush leaves the stack empty.
  `ASSERT_NEXT(a_flush_empties, clk, rst_n, q_pop && q_head_valid && q_head.flush, stat.empty, "stack not empty after flush")
  // The overflow flag only rises on a push into a full stack.
  `ASSERT_IMPL(a_ovf_on_full, clk, rst_n, $rose(stat.overflow), $past(stat.full), "overflow set without a full stack")
  // The overflow flag stays set until reset.
  `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, stat.overflow, stat.overflow, "overflow flag cleared")

endmodule
